// ===== src/okv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_pkg: shared types and codes of the ordered key/value table
// Word layouts, command and status codes, sequencer states, cell controls.
// ----------------------------------------------------------------------------
package okv_pkg;

    localparam int OKV_ENTRIES    = 64;
    localparam int OKV_KEY_BITS   = 32;
    localparam int OKV_VALUE_BITS = 32;

    localparam logic [2:0] CMD_ACCESS = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] STAT_FOUND    = 3'd0;
    localparam logic [2:0] STAT_INSERTED = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_ABSENT   = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value_out;
        logic [2:0]  status;
        logic [6:0]  entry_count;
    } out_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESOLVE,
        S_APPLY
    } state_t;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic hit_en;
        logic wr_en;
        logic shift_en;
    } cell_ctl_t;

endpackage

// ===== src/okv_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_cell: one entry of the ordered key/value chain
// Holds a key and a value, flags a key match, takes a direct write, or takes
// its upper neighbor's entry when an entry at or below it is removed.
// ----------------------------------------------------------------------------
module okv_cell
    import okv_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int KW    = 32,
    parameter int VW    = 32,
    parameter int CW    = 7,
    parameter int IW    = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctl_t     ctl,
    input  logic [CW-1:0] count,
    input  logic [IW-1:0] pos,
    input  logic [KW-1:0] search_key,
    input  logic [VW-1:0] new_value,
    input  logic [KW-1:0] up_key,
    input  logic [VW-1:0] up_value,
    output logic [KW-1:0] key,
    output logic [VW-1:0] value,
    output logic          hit
);

    logic [KW-1:0] key_reg;
    logic [VW-1:0] value_reg;
    logic          hit_reg;
    logic          hit_next;

    assign hit_next = (key_reg == search_key) && (CW'(INDEX) < count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.hit_en)
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (pos == IW'(INDEX)))
        begin
            key_reg   <= search_key;
            value_reg <= new_value;
        end
        else if (ctl.shift_en && (IW'(INDEX) >= pos))
        begin
            // close the gap: take the neighbor above
            key_reg   <= up_key;
            value_reg <= up_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

// ===== src/ordered_key_value_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_table_core: insertion-ordered associative table
// Chain of entry cells with parallel key compare; access, write, peek,
// remove with shift-down compaction, and clear.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_ready  | in_word  {command, key, value}
//  out      | out_valid / out_ready| out_word {value_out, status, entry_count}
//
// Each request steps through accept, compare in every cell, resolve the hit
// position and value, then update the chain and load the result register.
// The next request is accepted in the cycle after the update.
// Reset clears the entry count and the handshake state; entry storage is not
// cleared. A result held by a stalled out_ready delays the update cycle only.
// ----------------------------------------------------------------------------
module ordered_key_value_table_core
    import okv_pkg::*;
#(
    parameter int ENTRIES    = OKV_ENTRIES,
    parameter int KEY_BITS   = OKV_KEY_BITS,
    parameter int VALUE_BITS = OKV_VALUE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);

    state_t        state_reg, state_next;
    logic [2:0]    cmd_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg;
    logic [IW-1:0] hit_pos_reg;
    logic [VW-1:0] hit_val_reg;
    logic          out_valid_reg, out_valid_next;
    out_word_t     out_reg, out_next;

    logic          apply_go;
    logic          accept;
    logic          search_en;
    logic          cell_wr;
    logic          cell_shift;
    cell_ctl_t     ctl;
    logic [IW-1:0] cell_pos;
    logic [VW-1:0] cell_value;
    logic          found_next;
    logic [IW-1:0] hit_pos_next;
    logic [VW-1:0] hit_val_next;

    logic [KW-1:0]      cell_key [ENTRIES];
    logic [VW-1:0]      cell_val [ENTRIES];
    logic [ENTRIES-1:0] cell_hit;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_SEARCH;
            S_SEARCH:  state_next = S_RESOLVE;
            S_RESOLVE: state_next = S_APPLY;
            S_APPLY:   if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        apply_go  = 1'b0;
        search_en = 1'b0;
        case (state_reg)
            S_IDLE:    in_ready = 1'b1;
            S_SEARCH:  search_en = 1'b1;
            S_RESOLVE: ;
            S_APPLY:   apply_go = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    assign accept = in_valid && in_ready;

    assign ctl = '{hit_en: search_en, wr_en: cell_wr, shift_en: cell_shift};

    // ---------------- hit resolve ----------------
    always_comb
    begin
        found_next   = 1'b0;
        hit_pos_next = '0;
        hit_val_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cell_hit[i])
            begin
                found_next   = 1'b1;
                hit_pos_next = hit_pos_next | IW'(i);
                hit_val_next = hit_val_next | cell_val[i];
            end
        end
    end

    // ---------------- update and result ----------------
    always_comb
    begin
        cell_wr    = 1'b0;
        cell_shift = 1'b0;
        cell_pos   = hit_pos_reg;
        cell_value = val_reg;
        count_next = count_reg;
        out_next   = out_reg;
        if (apply_go)
        begin
            out_next.value_out = '0;
            out_next.status    = STAT_FOUND;
            case (cmd_reg)
                CMD_ACCESS, CMD_WRITE:
                begin
                    if (found_reg)
                    begin
                        if (cmd_reg == CMD_WRITE)
                        begin
                            cell_wr            = 1'b1;
                            out_next.value_out = 32'(val_reg);
                        end
                        else
                        begin
                            out_next.value_out = 32'(hit_val_reg);
                        end
                    end
                    else if (count_reg == CW'(ENTRIES))
                    begin
                        out_next.status = STAT_FULL;
                    end
                    else
                    begin
                        cell_wr         = 1'b1;
                        cell_pos        = count_reg[IW-1:0];
                        cell_value      = (cmd_reg == CMD_WRITE) ? val_reg : '0;
                        count_next      = CW'(count_reg + 1'b1);
                        out_next.status = STAT_INSERTED;
                        out_next.value_out = 32'(cell_value);
                    end
                end
                CMD_PEEK:
                begin
                    if (found_reg)
                        out_next.value_out = 32'(hit_val_reg);
                    else
                        out_next.status = STAT_ABSENT;
                end
                CMD_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        out_next.status = STAT_EMPTY;
                    end
                    else if (!found_reg)
                    begin
                        out_next.status = STAT_ABSENT;
                    end
                    else
                    begin
                        cell_shift = 1'b1;
                        count_next = CW'(count_reg - 1'b1);
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default: ;
            endcase
            out_next.entry_count = 7'(count_next);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_word.command;
            key_reg <= in_word.key[KW-1:0];
            val_reg <= in_word.value[VW-1:0];
        end
        if (state_reg == S_RESOLVE)
        begin
            found_reg   <= found_next;
            hit_pos_reg <= hit_pos_next;
            hit_val_reg <= hit_val_next;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        localparam int UP = (g + 1 < ENTRIES) ? g + 1 : g;

        okv_cell #(
            .INDEX (g),
            .KW    (KW),
            .VW    (VW),
            .CW    (CW),
            .IW    (IW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .count      (count_reg),
            .pos        (cell_pos),
            .search_key (key_reg),
            .new_value  (cell_value),
            .up_key     (cell_key[UP]),
            .up_value   (cell_val[UP]),
            .key        (cell_key[g]),
            .value      (cell_val[g]),
            .hit        (cell_hit[g])
        );
    end

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above table size");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESOLVE) |-> $onehot0(cell_hit))
        else $error("key matched in more than one entry");

    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result word without an update cycle");

    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SEARCH))
        else $error("accepted word did not start a search");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_APPLY) |=> $stable(count_reg))
        else $error("entry count changed outside the update cycle");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ordered_key_value_table_core
// A short table of directed requests (empty table, both key extremes, found
// and absent keys, remove with shift-down, spare command codes, clear) is
// followed by random fill, drain and mixed sequences that take the table to
// full and back. An in-bench model predicts each result word but those of
// fixed directed rows, which carry their own. Both channels idle in random
// bursts; the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb;
    import okv_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 1750;
    localparam int QUIET_TAIL   = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int POOL_SIZE    = 48;
    localparam int MAX_REPORTS  = 10;

    // spare command codes; the block must answer them without any change
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef enum int {MIX_SEQ, FILL_SEQ, DRAIN_SEQ} seq_kind_t;

    typedef struct {
        in_word_t  word;
        bit        fixed;
        out_word_t want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    // table contents as the block should hold them
    logic [31:0] tbl_keys [OKV_ENTRIES];
    logic [31:0] tbl_vals [OKV_ENTRIES];
    int          tbl_count = 0;

    stim_row_t   dir_rows [$];
    out_word_t   expected_q [$];
    logic [31:0] pool_keys [POOL_SIZE];

    int        total_words;
    int        quiet_from;
    int        pressure_at;
    int        words_in    = 0;
    int        issued      = 0;
    int        gap_left    = 0;
    bit        cur_fixed   = 1'b0;
    out_word_t cur_want    = '0;
    out_word_t got;
    out_word_t want;
    int        mismatches  = 0;
    int        stall_left  = 0;
    int        hold_left   = 0;
    bit        hold_done   = 1'b0;
    int        cycle_count = 0;
    seq_kind_t seq_kind    = FILL_SEQ;
    int        seq_left    = 90;

    ordered_key_value_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int find_entry(input logic [31:0] key);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Apply one request word to the table and return the result word it yields.
    function automatic out_word_t table_apply(input in_word_t w);
        out_word_t r;
        int        pos;
        r = '0;
        r.status = STAT_FOUND;
        case (w.command)
            CMD_ACCESS, CMD_WRITE:
            begin
                pos = find_entry(w.key);
                if (pos < 0 && tbl_count >= OKV_ENTRIES)
                    r.status = STAT_FULL;
                else
                begin
                    if (pos < 0)
                    begin
                        pos = tbl_count;
                        tbl_keys[pos] = w.key;
                        tbl_vals[pos] = '0;
                        tbl_count++;
                        r.status = STAT_INSERTED;
                    end
                    if (w.command == CMD_WRITE)
                        tbl_vals[pos] = w.value;
                    r.value_out = tbl_vals[pos];
                end
            end
            CMD_PEEK:
            begin
                pos = find_entry(w.key);
                if (pos < 0)
                    r.status = STAT_ABSENT;
                else
                    r.value_out = tbl_vals[pos];
            end
            CMD_REMOVE:
            begin
                if (tbl_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    pos = find_entry(w.key);
                    if (pos < 0)
                        r.status = STAT_ABSENT;
                    else
                    begin
                        // close the gap, keep insertion order
                        for (int i = pos; i + 1 < tbl_count; i++)
                        begin
                            tbl_keys[i] = tbl_keys[i + 1];
                            tbl_vals[i] = tbl_vals[i + 1];
                        end
                        tbl_count--;
                    end
                end
            end
            CMD_CLEAR:
                tbl_count = 0;
            default:
                ;
        endcase
        r.entry_count = 7'(tbl_count);
        return r;
    endfunction

    function automatic logic [31:0] random_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] present_key();
        if (tbl_count == 0)
            return random_data();
        return tbl_keys[$urandom_range(0, tbl_count - 1)];
    endfunction

    // Random request: fill, drain or mixed sequences plus a little noise.
    function automatic in_word_t random_request();
        in_word_t w;
        int       roll;
        if (seq_left == 0)
        begin
            seq_kind = seq_kind_t'($urandom_range(0, 2));
            seq_left = $urandom_range(20, 80);
        end
        seq_left--;
        roll    = $urandom_range(0, 99);
        w.value = random_data();
        w.key   = pool_keys[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 2)
            w.command = CMD_CLEAR;
        else if (roll < 5)
        begin
            case ($urandom_range(0, 2))
                0:       w.command = CMD_RSVD5;
                1:       w.command = CMD_RSVD6;
                default: w.command = CMD_RSVD7;
            endcase
        end
        else
        begin
            case (seq_kind)
                FILL_SEQ:
                begin
                    if (roll < 70)
                    begin
                        w.command = roll[0] ? CMD_WRITE : CMD_ACCESS;
                        w.key     = random_data();
                    end
                    else if (roll < 85)
                    begin
                        case ($urandom_range(0, 2))
                            0:       w.command = CMD_ACCESS;
                            1:       w.command = CMD_WRITE;
                            default: w.command = CMD_PEEK;
                        endcase
                        w.key = present_key();
                    end
                    else
                    begin
                        w.command = CMD_PEEK;
                        w.key     = random_data();
                    end
                end
                DRAIN_SEQ:
                begin
                    if (roll < 70)
                    begin
                        w.command = CMD_REMOVE;
                        w.key     = present_key();
                    end
                    else if (roll < 80)
                    begin
                        w.command = CMD_REMOVE;
                        w.key     = random_data();
                    end
                    else
                    begin
                        w.command = CMD_PEEK;
                        w.key     = present_key();
                    end
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       w.command = CMD_ACCESS;
                        1:       w.command = CMD_WRITE;
                        2:       w.command = CMD_PEEK;
                        default: w.command = CMD_REMOVE;
                    endcase
                    if (roll[0])
                        w.key = present_key();
                    if (roll < 8)
                        pool_keys[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
                end
            endcase
        end
        return w;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] key,
                           input logic [31:0] value, input bit fixed,
                           input logic [31:0] vout, input logic [2:0] st,
                           input logic [6:0] cnt);
        stim_row_t row;
        row.word.command     = cmd;
        row.word.key         = key;
        row.word.value       = value;
        row.fixed            = fixed;
        row.want.value_out   = vout;
        row.want.status      = st;
        row.want.entry_count = cnt;
        dir_rows.push_back(row);
    endtask

    // Result check, request prediction and request driving share one block so
    // that the table state is always current when the next request is built.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_word   <= '0;
            words_in  <= 0;
            issued    = 0;
            gap_left  = 0;
            tbl_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected word: value_out=%h status=%0d count=%0d",
                                 out_word.value_out, out_word.status, out_word.entry_count);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_word.value_out !== want.value_out
                        || out_word.status !== want.status
                        || out_word.entry_count !== want.entry_count)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("mismatch (value_out status count): expected %h %0d %0d, got %h %0d %0d",
                                     want.value_out, want.status, want.entry_count,
                                     out_word.value_out, out_word.status,
                                     out_word.entry_count);
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                got = table_apply(in_word);
                expected_q.push_back(cur_fixed ? cur_want : got);
                words_in <= words_in + 1;
            end

            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (issued >= total_words)
                    in_valid <= 1'b0;
                else if (issued < quiet_from && (issued / 100) % 3 != 0
                         && $urandom_range(0, 5) == 0)
                begin
                    // idle burst, counted from this cycle
                    gap_left = $urandom_range(1, 14) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    if (issued < dir_rows.size())
                    begin
                        in_word   <= dir_rows[issued].word;
                        cur_fixed = dir_rows[issued].fixed;
                        cur_want  = dir_rows[issued].want;
                    end
                    else
                    begin
                        in_word   <= random_request();
                        cur_fixed = 1'b0;
                    end
                    in_valid <= 1'b1;
                    issued++;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else if (!hold_done && words_in >= pressure_at)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (words_in < quiet_from && (words_in / 100) % 3 != 1
                 && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[ordered_key_value_table_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (pool_keys[i])
            pool_keys[i] = $urandom;
        pool_keys[0] = '0;
        pool_keys[1] = '1;

        //       command     key           value         fix   value_out     status         count
        add_row(CMD_PEEK,   32'h00000000, 32'h00000000, 1'b1, 32'h00000000, STAT_ABSENT,   7'd0);
        add_row(CMD_REMOVE, 32'h00000005, 32'h00000000, 1'b1, 32'h00000000, STAT_EMPTY,    7'd0);
        add_row(CMD_ACCESS, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, STAT_INSERTED, 7'd1);
        add_row(CMD_WRITE,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, STAT_INSERTED, 7'd2);
        add_row(CMD_WRITE,  32'h00000000, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, STAT_FOUND,    7'd2);
        add_row(CMD_ACCESS, 32'h00000000, 32'h5A5A5A5A, 1'b1, 32'hA5A5A5A5, STAT_FOUND,    7'd2);
        add_row(CMD_PEEK,   32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, STAT_FOUND,    7'd2);
        add_row(CMD_PEEK,   32'h12345678, 32'hFFFFFFFF, 1'b1, 32'h00000000, STAT_ABSENT,   7'd2);
        add_row(CMD_WRITE,  32'h5A5A5A5A, 32'h00000000, 1'b1, 32'h00000000, STAT_INSERTED, 7'd3);
        add_row(CMD_ACCESS, 32'h00000001, 32'hFFFFFFFF, 1'b1, 32'h00000000, STAT_INSERTED, 7'd4);
        // head removal shifts the other three down
        add_row(CMD_REMOVE, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, STAT_FOUND,    7'd3);
        add_row(CMD_PEEK,   32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, STAT_FOUND,    7'd3);
        add_row(CMD_PEEK,   32'h00000001, 32'h00000000, 1'b1, 32'h00000000, STAT_FOUND,    7'd3);
        add_row(CMD_REMOVE, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, STAT_ABSENT,   7'd3);
        add_row(CMD_REMOVE, 32'h00000001, 32'h00000000, 1'b1, 32'h00000000, STAT_FOUND,    7'd2);
        add_row(CMD_PEEK,   32'h5A5A5A5A, 32'h00000000, 1'b1, 32'h00000000, STAT_FOUND,    7'd2);
        add_row(CMD_RSVD5,  32'h00000000, 32'h00000000, 1'b1, 32'h00000000, STAT_FOUND,    7'd2);
        add_row(CMD_RSVD6,  32'h5A5A5A5A, 32'h12345678, 1'b1, 32'h00000000, STAT_FOUND,    7'd2);
        add_row(CMD_RSVD7,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000, STAT_FOUND,    7'd2);
        add_row(CMD_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000, STAT_FOUND,    7'd0);
        add_row(CMD_PEEK,   32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000, STAT_ABSENT,   7'd0);
        add_row(CMD_WRITE,  32'h80000000, 32'h13579BDF, 1'b0, '0, STAT_FOUND, '0);
        add_row(CMD_ACCESS, 32'h7FFFFFFF, 32'h00000000, 1'b0, '0, STAT_FOUND, '0);
        add_row(CMD_REMOVE, 32'h80000000, 32'h00000000, 1'b0, '0, STAT_FOUND, '0);

        total_words = dir_rows.size() + RANDOM_WORDS;
        quiet_from  = total_words - QUIET_TAIL;
        pressure_at = dir_rows.size() + 400;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in < total_words || expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[ordered_key_value_table_core] OK");
        else
            $display("[ordered_key_value_table_core] ERROR");
        $finish;
    end

endmodule
